>>> hdl/sensor_frame_crc_decoder_assert.svh
// Assertion macros shared by the sensor frame decoder modules.
`ifndef SENSOR_FRAME_CRC_DECODER_ASSERT_SVH
`define SENSOR_FRAME_CRC_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SFCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/sfcd_pkg.sv
// Types, constants and the CRC-8 step function of the sensor frame decoder.
package sfcd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic KIND_MEAS   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] POS_FIRST = 3'd0;
    localparam logic [2:0] POS_BYTE1 = 3'd1;
    localparam logic [2:0] POS_CRC0  = 3'd2;
    localparam logic [2:0] POS_WORD1 = 3'd3;
    localparam logic [2:0] POS_BYTE4 = 3'd4;
    localparam logic [2:0] POS_CRC1  = 3'd5;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_WORD0 = 2'd1;
    localparam logic [1:0] ERR_WORD1 = 2'd2;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUMI_SCALE  = 14'd10000;
    localparam logic [13:0] HUMI_MAX    = 14'd10000;

    // Completed frame handed from the byte front end to the converter.
    typedef struct packed {
        logic [15:0] w0;
        logic [15:0] w1;
        logic        kind;
        logic [1:0]  err;
    } t_frame_rec;

    // Result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic               pad;
        logic [1:0]         frame_error;
        logic [15:0]        status_value;
        logic [15:0]        humi_word;
        logic [15:0]        temp_word;
        logic [13:0]        humidity_centi;
        logic signed [14:0] temp_centi;
    } t_result;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/sfcd_front.sv
// Byte front end: frame position, CRC check and word capture.
module sfcd_front
    import sfcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_frame_kind,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_start,
    input  logic        i_full,
    output logic        o_push,
    output t_frame_rec  o_rec
);

    logic [2:0] r_pos, n_pos;
    logic [7:0] r_crc, n_crc;
    logic       r_first_ok, n_first_ok;
    logic [7:0] r_b0, r_b1, r_b3, r_b4;

    logic [2:0] len_m1;
    logic [2:0] pos_raw;
    logic [2:0] pos;
    logic       accept;
    logic       is_crc;
    logic       match;
    logic       first_ok;
    logic [7:0] crc_base;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        len_m1   = (i_frame_kind == KIND_STATUS) ? POS_CRC0 : POS_CRC1;
        pos_raw  = i_start ? POS_FIRST : r_pos;
        // restart the frame when the position runs past the current length
        pos      = (pos_raw > len_m1) ? POS_FIRST : pos_raw;
        is_crc   = pos inside {POS_CRC0, POS_CRC1};
        match    = (r_crc == i_byte);
        crc_base = (pos == POS_FIRST || pos == POS_WORD1) ? CRC_INIT : r_crc;
        first_ok = (pos == POS_CRC0) ? match : r_first_ok;

        n_pos      = r_pos;
        n_crc      = r_crc;
        n_first_ok = r_first_ok;
        if (accept) begin
            n_pos = (pos == len_m1) ? POS_FIRST : pos + 3'd1;
            if (is_crc) begin
                n_crc = CRC_INIT;
                if (pos == POS_CRC0) begin
                    n_first_ok = match;
                end
            end else begin
                n_crc = crc8_byte(crc_base, i_byte);
            end
        end

        o_push   = accept && is_crc && (pos == len_m1);
        o_rec.w0   = {r_b0, r_b1};
        o_rec.w1   = {r_b3, r_b4};
        o_rec.kind = i_frame_kind;
        if (!first_ok) begin
            o_rec.err = ERR_WORD0;
        end else if (i_frame_kind == KIND_STATUS) begin
            o_rec.err = ERR_OK;
        end else if (!match) begin
            o_rec.err = ERR_WORD1;
        end else begin
            o_rec.err = ERR_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_FIRST;
            r_crc      <= CRC_INIT;
            r_first_ok <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_first_ok <= n_first_ok;
        end
    end

    // hold the data bytes of the current frame
    always_ff @(posedge i_clk) begin
        if (accept) begin
            case (pos)
                POS_FIRST: r_b0 <= i_byte;
                POS_BYTE1: r_b1 <= i_byte;
                POS_WORD1: r_b3 <= i_byte;
                POS_BYTE4: r_b4 <= i_byte;
                default: ;
            endcase
        end
    end

`include "sensor_frame_crc_decoder_assert.svh"
    `SFCD_ASSERT(a_pos_range, i_clk, i_rst_n, (r_pos <= POS_CRC1), "byte position out of range")
    `SFCD_ASSERT_IMP(a_push_accept, i_clk, i_rst_n, o_push, (accept && is_crc), "push without crc byte")

endmodule

>>> hdl/sfcd_queue.sv
// Short queue of completed frames between the front end and the converter.
module sfcd_queue
    import sfcd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_frame_rec  i_rec,
    input  logic        i_pop,
    output t_frame_rec  o_rec,
    output logic        o_empty,
    output logic        o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame_rec          r_mem [DEPTH];
    logic [PW-1:0]       r_wr, r_rd;
    logic [CW-1:0]       r_count;
    logic                push, pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign push    = i_push && !o_full;
    assign pop     = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "sensor_frame_crc_decoder_assert.svh"
    `SFCD_ASSERT(a_count_max, i_clk, i_rst_n, (r_count <= CW'(DEPTH)), "queue overfilled")
    `SFCD_ASSERT_IMP(a_no_drop, i_clk, i_rst_n, i_push, !o_full, "frame pushed into full queue")

endmodule

>>> hdl/sfcd_back.sv
// Converter: scales the raw words and registers the result item.
module sfcd_back
    import sfcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_rec  i_rec,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);

    logic        r_s1_vld;
    t_frame_rec  r_s1_rec;
    logic [30:0] r_s1_tprod;
    logic [29:0] r_s1_hprod;
    logic        r_out_vld;
    t_result     r_out;

    logic        s1_adv;
    logic [31:0] tsum;
    logic [31:0] hsum;
    logic [14:0] tq;
    logic [13:0] hq;
    t_result     n_out;

    assign s1_adv  = r_s1_vld && (!r_out_vld || i_ready);
    assign o_pop   = !i_empty && (!r_s1_vld || s1_adv);
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    // floor(x / 65535) as (x + (x >> 16) + 1) >> 16, exact for these ranges
    always_comb begin
        tsum = 32'(r_s1_tprod) + 32'(r_s1_tprod >> 16) + 32'd1;
        hsum = 32'(r_s1_hprod) + 32'(r_s1_hprod >> 16) + 32'd1;
        tq   = tsum[30:16];
        hq   = hsum[29:16];

        n_out = '0;
        n_out.frame_error = r_s1_rec.err;
        if (r_s1_rec.err == ERR_OK) begin
            if (r_s1_rec.kind == KIND_STATUS) begin
                n_out.status_value = r_s1_rec.w0;
            end else begin
                n_out.temp_centi     = $signed(tq - TEMP_OFFSET);
                n_out.humidity_centi = (hq > HUMI_MAX) ? HUMI_MAX : hq;
                n_out.temp_word      = r_s1_rec.w0;
                n_out.humi_word      = r_s1_rec.w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_rec   <= i_rec;
            r_s1_tprod <= 31'(TEMP_SCALE) * 31'(i_rec.w0);
            r_s1_hprod <= 30'(HUMI_SCALE) * 30'(i_rec.w1);
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

`include "sensor_frame_crc_decoder_assert.svh"
    `SFCD_ASSERT_IMP(a_humi_clamp, i_clk, i_rst_n, r_out_vld, (r_out.humidity_centi <= HUMI_MAX), "humidity above full scale")
    `SFCD_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, (r_out_vld && r_out.frame_error != ERR_OK), (r_out.temp_word == 16'd0 && r_out.status_value == 16'd0 && r_out.temp_centi == 15'sd0), "error result carries data")

endmodule

>>> hdl/sensor_frame_crc_decoder.sv
// Top level of the sensor response frame decoder with CRC-8 check.
// One byte per item, one item per clock: the front end checks the CRC-8 of each
// word (poly 0x31, init 0xFF) and follows the frame position, and the last byte
// of a frame (the third byte for a status frame, the sixth for a measurement
// frame) hands the frame to a queue of Q_DEPTH entries. A two-stage converter
// (multiply, then divide-by-65535 correction and offset) turns it into one
// result item; both stages are registered. Input is taken every cycle while
// the queue has room, so only a result side stalled long enough to fill the
// queue holds input back. frame_kind is written through the cfg channel, which
// is always ready; write it only between frames.
module sensor_frame_crc_decoder
    import sfcd_pkg::*;
#(
    parameter int Q_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,       // frame_kind
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tuser,   // frame_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // temp_centi[14:0], humidity_centi[28:15], temp_word[44:29],
    // humi_word[60:45], status_value[76:61], frame_error[78:77], zero[79]
    output logic [79:0] o_m_axis_tdata
);

    logic       r_frame_kind;
    logic       q_push, q_pop, q_empty, q_full;
    t_frame_rec f_rec, q_rec;
    t_result    res;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_kind <= KIND_MEAS;
        end else if (i_cfg_valid) begin
            r_frame_kind <= i_cfg_data;
        end
    end

    sfcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_kind (r_frame_kind),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_byte       (i_s_axis_tdata),
        .i_start      (i_s_axis_tuser),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_rec        (f_rec)
    );

    sfcd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .i_pop   (q_pop),
        .o_rec   (q_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sfcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (q_rec),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

endmodule
